[hw/rtl/mfc_pkg.sv]
// Shared constants, codes and control structs for the mailbox FIFO pair controller.
package mfc_pkg;

  localparam int FIFO_DEPTH = 8;
  localparam int CHANNELS   = 9;
  localparam logic [31:0] INVALID_WORD = 32'h0000_000f;

  localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int LAT_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_W      = 4;

  localparam logic [CH_W:0]  CH_LIMIT  = (CH_W + 1)'(CHANNELS);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  localparam logic [31:0] BIT_FULL    = 32'h8000_0000;
  localparam logic [31:0] BIT_EMPTY   = 32'h4000_0000;
  localparam logic [31:0] BIT_ENABLE  = 32'h0000_0001;
  localparam logic [31:0] BIT_PENDING = 32'h0000_0010;

  localparam logic [7:0] OFS_POP_LO     = 8'h80;
  localparam logic [7:0] OFS_POP_HI     = 8'h8c;
  localparam logic [7:0] OFS_PEEK       = 8'h90;
  localparam logic [7:0] OFS_SENDER     = 8'h94;
  localparam logic [7:0] OFS_STATUS     = 8'h98;
  localparam logic [7:0] OFS_CONFIG     = 8'h9c;
  localparam logic [7:0] OFS_REQ_LO     = 8'ha0;
  localparam logic [7:0] OFS_REQ_HI     = 8'hac;
  localparam logic [7:0] OFS_REQ_STATUS = 8'hb8;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;

  typedef struct packed {
    logic pop;
    logic push;
  } fifo_ctl_t;

  typedef struct packed {
    logic head_valid;
    logic full;
  } fifo_stat_t;

endpackage

[hw/rtl/mailbox_fifo_pair_controller_core.sv]
// Top level of the mailbox FIFO pair controller: command decode, latches and sequencing.
//
// Usage: a transaction is offered on the in_ ports with start; it is taken at a
// rising edge where start is high and busy is low. Op 0 is a bus read, op 1 a
// bus write, op 2 a child channel level event. Every transaction produces exactly
// one result, presented on the out_ ports for a single cycle with out_valid high.
// The receiver cannot stall: a result must be captured in the cycle it is shown.
//
// Sequencing: the command itself is applied in the accept cycle. Afterwards the
// block drains latched child responses into the response FIFO, one word per
// cycle, lowest channel first, until none remain or the FIFO is full. A closing
// step then ends the transaction and the result strobe follows. At most FIFO_DEPTH
// words are moved; busy is high while the block drains and closes, and a new
// start may be accepted in the cycle the strobe is shown.
//
// Reset (rst_n low, synchronous) empties both FIFOs, clears all latched flags and
// the interrupt enable, and returns the block to idle with no strobe pending.
module mailbox_fifo_pair_controller_core
  import mfc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_op,
  input  logic [7:0]          in_offset,
  input  logic [31:0]         in_word,
  input  logic [CH_W-1:0]     in_event_channel,
  input  logic                in_event_level,
  input  logic [CHANNELS-1:0] in_busy_mask,
  output logic                out_valid,
  output logic [31:0]         out_read_data,
  output logic                out_irq,
  output logic                out_child_write_valid,
  output logic [CH_W-1:0]     out_child_write_channel,
  output logic [31:0]         out_child_write_word,
  output logic                out_queue_full_drop,
  output logic                out_bad_channel,
  output logic                out_unsupported_access
);

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  state_t state_r;

  // Result registers, loaded on accept; out_valid_r and irq_r load on closing.
  logic                out_valid_r;
  logic [31:0]         rdata_r;
  logic                irq_r;
  logic                cw_valid_r;
  logic [CH_W-1:0]     cw_ch_r;
  logic [31:0]         cw_word_r;
  logic                full_drop_r;
  logic                bad_ch_r;
  logic                unsup_r;

  // Control state.
  logic [CHANNELS-1:0] lat_valid_r;
  logic [31:0]         lat_word_r [CHANNELS];
  logic [CNT_W-1:0]    req_cnt_r;
  logic                irq_en_r;

  // Response FIFO interface.
  fifo_ctl_t           fifo_ctl;
  fifo_stat_t          fifo_stat;
  logic [31:0]         fifo_head;
  logic [31:0]         push_word;

  // Decode of the offered transaction.
  logic                accept;
  logic                is_pop_ofs;
  logic                is_req_ofs;
  logic [31:0]         head_or_inv;
  logic                req_full;
  logic [CH_W-1:0]     req_ch;
  logic                req_ch_ok;
  logic                req_queue;
  logic                ev_ch_ok;
  logic [LAT_IDX_W-1:0] ev_idx;

  logic [31:0]         rdata_nxt;
  logic                cw_valid_nxt;
  logic                full_drop_nxt;
  logic                bad_ch_nxt;
  logic                unsup_nxt;

  // Drain selection.
  logic                any_lat;
  logic                can_push;
  logic [LAT_IDX_W-1:0] lat_sel;

  assign accept      = start && !busy;
  assign busy        = (state_r != ST_IDLE);
  assign is_pop_ofs  = (in_offset >= OFS_POP_LO) && (in_offset <= OFS_POP_HI);
  assign is_req_ofs  = (in_offset >= OFS_REQ_LO) && (in_offset <= OFS_REQ_HI);
  assign head_or_inv = fifo_stat.head_valid ? fifo_head : INVALID_WORD;
  assign req_full    = (req_cnt_r >= CNT_FULL);
  assign req_ch      = in_word[CH_W-1:0];
  assign req_ch_ok   = ({1'b0, req_ch} < CH_LIMIT);
  assign ev_ch_ok    = ({1'b0, in_event_channel} < CH_LIMIT);
  assign ev_idx      = in_event_channel[LAT_IDX_W-1:0];

  // A request write to a busy child goes into the request FIFO. Nothing in
  // this block drains that FIFO, so only its fill level is tracked.
  assign req_queue = (in_op == OP_WRITE) && is_req_ofs && !req_full && req_ch_ok
                     && in_busy_mask[req_ch[LAT_IDX_W-1:0]];

  // Result fields of the accepted transaction.
  always_comb begin
    rdata_nxt     = '0;
    cw_valid_nxt  = 1'b0;
    full_drop_nxt = 1'b0;
    bad_ch_nxt    = 1'b0;
    unsup_nxt     = 1'b0;
    unique case (in_op)
      OP_READ: begin
        priority if (is_pop_ofs) begin
          rdata_nxt = head_or_inv;
        end else if (in_offset == OFS_PEEK) begin
          rdata_nxt = head_or_inv;
        end else if (in_offset == OFS_SENDER) begin
          rdata_nxt = '0;
        end else if (in_offset == OFS_STATUS) begin
          rdata_nxt = !fifo_stat.head_valid ? BIT_EMPTY
                    : (fifo_stat.full ? BIT_FULL : '0);
        end else if (in_offset == OFS_CONFIG) begin
          // Between transactions the pending flag equals a nonempty response FIFO.
          rdata_nxt = (irq_en_r ? BIT_ENABLE : '0)
                    | (fifo_stat.head_valid ? BIT_PENDING : '0);
        end else if (in_offset == OFS_REQ_STATUS) begin
          rdata_nxt = (req_cnt_r == '0) ? BIT_EMPTY : (req_full ? BIT_FULL : '0);
        end else begin
          unsup_nxt = 1'b1;
        end
      end
      OP_WRITE: begin
        priority if (in_offset == OFS_SENDER || in_offset == OFS_CONFIG) begin
          unsup_nxt = 1'b0;
        end else if (is_req_ofs) begin
          priority if (req_full) begin
            full_drop_nxt = 1'b1;
          end else if (!req_ch_ok) begin
            bad_ch_nxt = 1'b1;
          end else if (!in_busy_mask[req_ch[LAT_IDX_W-1:0]]) begin
            cw_valid_nxt = 1'b1;
          end else begin
            cw_valid_nxt = 1'b0;
          end
        end else begin
          unsup_nxt = 1'b1;
        end
      end
      default: begin
        unsup_nxt = 1'b0;
      end
    endcase
  end

  // Lowest latched channel is drained first.
  always_comb begin
    lat_sel = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (lat_valid_r[i]) begin
        lat_sel = LAT_IDX_W'(i);
      end
    end
  end

  assign any_lat   = |lat_valid_r;
  assign can_push  = (state_r == ST_DRAIN) && any_lat && !fifo_stat.full;
  assign push_word = lat_word_r[lat_sel];

  assign fifo_ctl.pop  = accept && (in_op == OP_READ) && is_pop_ofs;
  assign fifo_ctl.push = can_push;

  mfc_resp_fifo u_resp_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (fifo_ctl),
    .push_word (push_word),
    .stat      (fifo_stat),
    .head_word (fifo_head)
  );

  // Sequencer and result registers. The strobe is registered from the drain step
  // that finds nothing more to push, and lasts exactly one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          out_valid_r <= 1'b0;
          if (accept) begin
            state_r     <= ST_DRAIN;
            rdata_r     <= rdata_nxt;
            cw_valid_r  <= cw_valid_nxt;
            cw_ch_r     <= cw_valid_nxt ? req_ch : '0;
            cw_word_r   <= cw_valid_nxt ? in_word : '0;
            full_drop_r <= full_drop_nxt;
            bad_ch_r    <= bad_ch_nxt;
            unsup_r     <= unsup_nxt;
          end
        end
        ST_DRAIN: begin
          out_valid_r <= !can_push;
          if (!can_push) begin
            state_r <= ST_IDLE;
            irq_r   <= fifo_stat.head_valid && irq_en_r;
          end
        end
        default: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  // Latch flags, request fill level and interrupt enable.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_valid_r <= '0;
      req_cnt_r   <= '0;
      irq_en_r    <= 1'b0;
    end else begin
      if (accept && (in_op == OP_WRITE) && (in_offset == OFS_CONFIG)) begin
        irq_en_r <= in_word[0];
      end
      if (accept && req_queue) begin
        req_cnt_r <= req_cnt_r + CNT_W'(1);
      end
      if (accept && (in_op == OP_EVENT) && ev_ch_ok) begin
        lat_valid_r[ev_idx] <= in_event_level;
      end
      if (can_push) begin
        lat_valid_r[lat_sel] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_op == OP_EVENT) && ev_ch_ok && in_event_level) begin
      lat_word_r[ev_idx] <= in_word;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_read_data           = rdata_r;
  assign out_irq                 = irq_r;
  assign out_child_write_valid   = cw_valid_r;
  assign out_child_write_channel = cw_ch_r;
  assign out_child_write_word    = cw_word_r;
  assign out_queue_full_drop     = full_drop_r;
  assign out_bad_channel         = bad_ch_r;
  assign out_unsupported_access  = unsup_r;

`ifndef SYNTH
  // The result strobe only appears once the sequencer has returned to idle.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // An accepted transaction always raises busy in the cycle after it is taken.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // A forwarded request is never also reported as dropped.
  a_forward_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_child_write_valid && (out_queue_full_drop || out_bad_channel)))
    else $error("forwarded request also flagged as dropped");

  // The interrupt level requires both the enable and a nonempty response FIFO.
  a_irq_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_irq) |-> (irq_en_r && fifo_stat.head_valid))
    else $error("interrupt without enable or pending data");
`endif

endmodule

[hw/rtl/mfc_resp_cell.sv]
// One cell of the response FIFO chain: a word, its valid bit and the hand-off to its neighbor.
module mfc_resp_cell
  import mfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  fifo_ctl_t   ctl,
  input  logic        prev_valid,
  input  logic        next_valid,
  input  logic [31:0] next_word,
  input  logic [31:0] push_word,
  output logic        valid,
  output logic [31:0] word
);

  logic        valid_r, valid_nxt;
  logic [31:0] word_r, word_nxt;

  // A pop moves every word one place toward the head; a push lands in the
  // first empty cell, which is the one whose predecessor is occupied.
  always_comb begin
    valid_nxt = valid_r;
    word_nxt  = word_r;
    if (ctl.pop) begin
      valid_nxt = next_valid;
      word_nxt  = next_word;
    end else if (ctl.push && !valid_r && prev_valid) begin
      valid_nxt = 1'b1;
      word_nxt  = push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign valid = valid_r;
  assign word  = word_r;

endmodule

[hw/rtl/mfc_resp_fifo.sv]
// Response FIFO built as a row of cells that shift toward the head on a pop.
module mfc_resp_fifo
  import mfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  fifo_ctl_t   ctl,
  input  logic [31:0] push_word,
  output fifo_stat_t  stat,
  output logic [31:0] head_word
);

  logic [FIFO_DEPTH-1:0] cell_valid;
  logic [31:0]           cell_word [FIFO_DEPTH];

  for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_cell
    logic        prev_v;
    logic        next_v;
    logic [31:0] next_w;

    if (i == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_body
      assign prev_v = cell_valid[i-1];
    end

    if (i == FIFO_DEPTH - 1) begin : g_tail
      assign next_v = 1'b0;
      assign next_w = INVALID_WORD;
    end else begin : g_inner
      assign next_v = cell_valid[i+1];
      assign next_w = cell_word[i+1];
    end

    mfc_resp_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .prev_valid (prev_v),
      .next_valid (next_v),
      .next_word  (next_w),
      .push_word  (push_word),
      .valid      (cell_valid[i]),
      .word       (cell_word[i])
    );
  end

  assign stat.head_valid = cell_valid[0];
  assign stat.full       = cell_valid[FIFO_DEPTH-1];
  assign head_word       = cell_word[0];

endmodule
